@@ src/rotated_sorted_array_search_unit_macros.svh @@
// Assertion macros used by the checker of the search unit.
`ifndef ROTATED_SORTED_ARRAY_SEARCH_UNIT_MACROS_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while reset is low.
`define RSAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while reset is low.
`define RSAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rsas_pkg.sv @@
package rsas_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OUT_W      = 11;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    localparam logic [OUT_W-1:0] NOT_FOUND = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_PV_ADDR,
        ST_PV_CMP,
        ST_SR_ADDR,
        ST_SR_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } t_ram_req;

    typedef struct packed {
        logic             valid;
        logic [OUT_W-1:0] index;
    } t_result;

endpackage

@@ src/rsas_ram.sv @@
module rsas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/rsas_ctrl.sv @@
module rsas_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_in_func,
    input  logic                                i_in_start,
    input  logic [rsas_pkg::DATA_WIDTH-1:0]     i_in_value,
    input  logic                                i_out_free,
    output rsas_pkg::t_result                   o_result,
    output rsas_pkg::t_ram_req                  o_ram,
    input  logic [rsas_pkg::DATA_WIDTH-1:0]     i_rd_data
);

    rsas_pkg::t_state r_state, n_state;

    logic [rsas_pkg::CNT_W-1:0]      r_count, n_count;
    logic [rsas_pkg::CNT_W-1:0]      r_lo, n_lo;
    logic [rsas_pkg::CNT_W-1:0]      r_hi, n_hi;
    logic [rsas_pkg::CNT_W-1:0]      r_mid, n_mid;
    logic [rsas_pkg::DATA_WIDTH-1:0] r_key, n_key;
    logic [rsas_pkg::DATA_WIDTH-1:0] r_first, n_first;
    logic                            r_key_gt, n_key_gt;
    logic [rsas_pkg::OUT_W-1:0]      r_res, n_res;

    logic                            accept;
    logic [rsas_pkg::DATA_WIDTH-1:0] cmp_b;
    logic                            cmp_lt;
    logic                            cmp_eq;
    logic [rsas_pkg::CNT_W:0]        idx_sum;
    logic [rsas_pkg::CNT_W-1:0]      mid_c;
    logic [rsas_pkg::CNT_W-1:0]      last_idx;
    logic                            store_full;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == rsas_pkg::ST_IDLE);
    assign last_idx   = r_count - 1'b1;
    assign store_full = (r_count == rsas_pkg::CNT_W'(rsas_pkg::DEPTH));

    // Shared compare unit: RAM word against the key or the first element.
    assign cmp_b  = (r_state == rsas_pkg::ST_RD_FIRST || r_state == rsas_pkg::ST_SR_CMP)
                    ? r_key : r_first;
    assign cmp_lt = $signed(i_rd_data) < $signed(cmp_b);
    assign cmp_eq = (i_rd_data == cmp_b);

    // Shared index adder: midpoint of the current window.
    assign idx_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_c   = idx_sum[rsas_pkg::CNT_W:1];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rsas_pkg::ST_IDLE: begin
                if (accept && i_in_func == rsas_pkg::FUNC_SEARCH) begin
                    n_state = (r_count == '0) ? rsas_pkg::ST_DONE : rsas_pkg::ST_RD_FIRST;
                end
            end
            rsas_pkg::ST_RD_FIRST: begin
                n_state = cmp_eq ? rsas_pkg::ST_DONE : rsas_pkg::ST_RD_LAST;
            end
            rsas_pkg::ST_RD_LAST: begin
                n_state = cmp_lt ? rsas_pkg::ST_PV_ADDR : rsas_pkg::ST_SR_ADDR;
            end
            rsas_pkg::ST_PV_ADDR: begin
                n_state = (r_lo < r_hi) ? rsas_pkg::ST_PV_CMP : rsas_pkg::ST_SR_ADDR;
            end
            rsas_pkg::ST_PV_CMP: begin
                n_state = rsas_pkg::ST_PV_ADDR;
            end
            rsas_pkg::ST_SR_ADDR: begin
                n_state = (r_lo <= r_hi) ? rsas_pkg::ST_SR_CMP : rsas_pkg::ST_DONE;
            end
            rsas_pkg::ST_SR_CMP: begin
                n_state = cmp_eq ? rsas_pkg::ST_DONE : rsas_pkg::ST_SR_ADDR;
            end
            rsas_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = rsas_pkg::ST_IDLE;
                end
            end
            default: n_state = rsas_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_key    = r_key;
        n_first  = r_first;
        n_key_gt = r_key_gt;
        n_res    = r_res;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_count[rsas_pkg::ADDR_W-1:0];
        o_ram.wdata = i_in_value;
        o_ram.raddr = '0;
        o_result.valid = (r_state == rsas_pkg::ST_DONE);
        o_result.index = r_res;
        unique case (r_state)
            rsas_pkg::ST_IDLE: begin
                if (accept && i_in_func == rsas_pkg::FUNC_LOAD) begin
                    if (i_in_start) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = '0;
                        n_count     = rsas_pkg::CNT_W'(1);
                    end else if (!store_full) begin
                        o_ram.we = 1'b1;
                        n_count  = r_count + 1'b1;
                    end
                end else if (accept) begin
                    n_key = i_in_value;
                    n_res = rsas_pkg::NOT_FOUND;
                end
            end
            rsas_pkg::ST_RD_FIRST: begin
                n_first     = i_rd_data;
                n_key_gt    = cmp_lt;
                if (cmp_eq) begin
                    n_res = '0;
                end
                o_ram.raddr = last_idx[rsas_pkg::ADDR_W-1:0];
            end
            rsas_pkg::ST_RD_LAST: begin
                if (cmp_lt) begin
                    // Rotated: hunt for the pivot in [1, n-1].
                    n_lo = rsas_pkg::CNT_W'(1);
                    n_hi = last_idx;
                end else if (r_key_gt) begin
                    n_lo = rsas_pkg::CNT_W'(1);
                    n_hi = last_idx;
                end else begin
                    n_lo = r_count;
                    n_hi = last_idx;
                end
            end
            rsas_pkg::ST_PV_ADDR: begin
                if (r_lo < r_hi) begin
                    n_mid       = mid_c;
                    o_ram.raddr = mid_c[rsas_pkg::ADDR_W-1:0];
                end else if (r_key_gt) begin
                    // Pivot is lo-1: search the upper run.
                    n_lo = rsas_pkg::CNT_W'(1);
                    n_hi = r_lo - 1'b1;
                end else begin
                    n_hi = last_idx;
                end
            end
            rsas_pkg::ST_PV_CMP: begin
                if (cmp_lt) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + 1'b1;
                end
            end
            rsas_pkg::ST_SR_ADDR: begin
                if (r_lo <= r_hi) begin
                    n_mid       = mid_c;
                    o_ram.raddr = mid_c[rsas_pkg::ADDR_W-1:0];
                end
            end
            rsas_pkg::ST_SR_CMP: begin
                if (cmp_eq) begin
                    n_res = rsas_pkg::OUT_W'(r_mid);
                end else if (cmp_lt) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid - 1'b1;
                end
            end
            rsas_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsas_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_key    <= n_key;
        r_first  <= n_first;
        r_key_gt <= n_key_gt;
        r_res    <= n_res;
    end

endmodule

@@ src/rotated_sorted_array_search_unit.sv @@
// Rotated sorted array search unit.
// Input stream (s_axis): tdata carries value, a signed 32-bit word; tuser[0] is func
// (0 load, 1 search) and tuser[1] is start_new. A load item writes value at the next
// free index of a 1024-entry store; start_new restarts the array at index zero. Loads
// into a full store are dropped. A search item looks the key up in the loaded array,
// which is expected to be ascending, distinct and rotated.
// Output stream (m_axis): one item per search, tdata[10:0] is found_index (signed),
// the index holding the key or -1; bits above are zero. Loads give no output item.
// A load keeps ready high, so the next item is taken right away. A search runs
// on one compare unit and one index adder under a sequencer, one registered RAM read
// per step: the first and last words are read, then the pivot and then the key are
// found by halving, with an address state and a compare state per halving step as the
// RAM read is registered, and the result is handed over. Ready stays low until the
// result is handed over; a key equal to the first word skips both halvings.
// The result sits in an output register; while the receiver stalls, later loads are
// still taken, and a later search finishes and then holds until that register frees.
// Reset (synchronous, active low) empties the array and drops any pending result;
// the store itself is not cleared, since only written entries are ever read.
module rotated_sorted_array_search_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [rsas_pkg::DATA_WIDTH-1:0]      i_s_axis_tdata,  // [31:0] value
    input  logic [1:0]                           i_s_axis_tuser,  // [0] func, [1] start_new
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [rsas_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata   // [10:0] found_index
);

    rsas_pkg::t_ram_req              ram_req;
    rsas_pkg::t_result               result;
    logic [rsas_pkg::DATA_WIDTH-1:0] rd_data;
    logic                            out_free;

    logic                            r_out_valid, n_out_valid;
    logic [rsas_pkg::OUT_W-1:0]      r_out_index, n_out_index;

    // Output slot is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || i_m_axis_tready;

    rsas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_in_func  (i_s_axis_tuser[0]),
        .i_in_start (i_s_axis_tuser[1]),
        .i_in_value (i_s_axis_tdata),
        .i_out_free (out_free),
        .o_result   (result),
        .o_ram      (ram_req),
        .i_rd_data  (rd_data)
    );

    rsas_ram #(
        .WIDTH (rsas_pkg::DATA_WIDTH),
        .DEPTH (rsas_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

    // Output register: load a finished result when the slot frees, drop valid on drain.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_index = r_out_index;
        if (result.valid && out_free) begin
            n_out_valid = 1'b1;
            n_out_index = result.index;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_index <= n_out_index;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = rsas_pkg::OUT_TDATA_W'(r_out_index);

endmodule

@@ src/rsas_chk.sv @@
`include "rotated_sorted_array_search_unit_macros.svh"

module rsas_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [rsas_pkg::DATA_WIDTH-1:0]  i_s_axis_tdata,
    input logic [1:0]                       i_s_axis_tuser,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [rsas_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic in_acc;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // A stalled result holds.
    `RSAS_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "output item changed while stalled")

    // A taken search item drops input ready.
    `RSAS_ASSERT_NEXT(a_search_busy, in_acc && i_s_axis_tuser[0] == rsas_pkg::FUNC_SEARCH, !o_s_axis_tready, "input ready right after a search item")

    // A load never blocks the input.
    `RSAS_ASSERT_NEXT(a_load_free, in_acc && i_s_axis_tuser[0] == rsas_pkg::FUNC_LOAD, o_s_axis_tready, "input not ready after a load item")

    // Result is -1 or a non-negative index with zero padding.
    `RSAS_ASSERT_NOW(a_out_range, o_m_axis_tvalid, (o_m_axis_tdata[rsas_pkg::OUT_TDATA_W-1:rsas_pkg::OUT_W] == '0) && (!o_m_axis_tdata[rsas_pkg::OUT_W-1] || o_m_axis_tdata[rsas_pkg::OUT_W-1:0] == rsas_pkg::NOT_FOUND), "found_index out of range")

endmodule

bind rotated_sorted_array_search_unit rsas_chk u_rsas_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
